// ===== rtl/fat_cluster_chain_manager_unit_assert.svh =====
// Assertion macro used by the checker of the cluster chain manager.
// No dependencies.
`ifndef FAT_CLUSTER_CHAIN_MANAGER_UNIT_ASSERT_SVH
`define FAT_CLUSTER_CHAIN_MANAGER_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define FCCM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

// ===== rtl/fccm_pkg.sv =====
// Package of the cluster chain manager: cluster count, marks, action and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fccm_pkg;
	localparam int CLUSTERS_DEF = 4096;
	localparam logic [15:0] END_MARK = 16'hFFFF;
	localparam logic [15:0] FREE_MARK = 16'h0000;
	typedef enum logic [2:0] {
		ACT_ALLOC = 3'd0, ACT_FREE = 3'd1, ACT_FREE_REST = 3'd2, ACT_COUNT = 3'd3,
		ACT_LAST = 3'd4, ACT_READ = 3'd5, ACT_WRITE = 3'd6, ACT_SET = 3'd7
	} action_t;
	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_NO_FREE = 3'd1, ST_RANGE = 3'd2, ST_LOOP = 3'd3, ST_EMPTY = 3'd4
	} status_t;
endpackage
`default_nettype wire

// ===== rtl/fat_cluster_chain_manager_unit.sv =====
// Top level of the FAT cluster chain manager: sequencer around one link RAM.
// Depends on fccm_pkg and fccm_ram.
//
// Channel  Dir  Fields (tdata from bit 0)
// s_axis   in   action[2:0] cluster[18:3] has_previous[19] value[35:20]
// m_axis   out  status[2:0] result_cluster[18:3] chain_length[31:19] free_total[44:32]
//
// Every request is handled by one sequencer that does at most one RAM access per cycle.
// After reset a clearing pass writes every entry to zero, during which no request is
// taken. A range error found at acceptance goes straight to DONE; read
// and set pass through RD, write through RD and REL_WR. Counting or finding the last
// cluster of a chain reads each link in WALK; freeing walks it again in REL/REL_WR.
// Allocation passes ALLOC_HINT, ALLOC_NEXT, MARK_END and CHECK_NEXT when the hint and
// the entry after the new cluster are free, else adds table scans, at most two per
// transaction. The result sits in an output register; one more transaction may be
// accepted while it waits, and that one stalls in DONE until the register is taken.
`timescale 1ns / 1ps
`default_nettype none
module fat_cluster_chain_manager_unit #(
	parameter int CLUSTERS = fccm_pkg::CLUSTERS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// action, cluster, has_previous, value, zero pad
	input wire logic [39:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	// status, result_cluster, chain_length, free_total, zero pad
	output logic [47:0] m_axis_tdata
);
	import fccm_pkg::*;
	localparam int AW = $clog2(CLUSTERS);
	localparam int CW = $clog2(CLUSTERS + 1);
	localparam logic [16:0] NCL = 17'(CLUSTERS);

	typedef enum logic [3:0] {
		CLR, IDLE, RD, ALLOC_HINT, SCAN, ALLOC_NEXT, MARK_END, CHECK_NEXT, WALK, REL, REL_WR,
		DONE
	} state_t;
	state_t state_q;

	logic we;
	logic [AW-1:0] addr;
	logic [15:0] wdata, rdata;
	fccm_ram #(.WIDTH(16), .DEPTH(CLUSTERS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata));

	// Request fields latched at acceptance.
	logic [2:0] act_q;
	logic [15:0] cl_q, val_q;
	logic prev_q;
	// Working registers.
	logic [15:0] cur_q, pick_q, last_q;
	logic [16:0] len_q, cnt_q, scan_q;
	logic [CW-1:0] free_q;
	logic [AW-1:0] hint_q;
	logic phase_q, scan_next_q, first_q;
	logic [2:0] st_q;
	logic [15:0] res_q;
	logic [12:0] olen_q;
	// Output register, loaded when a transaction finishes.
	logic out_v_q;
	logic [2:0] out_st_q;
	logic [15:0] out_res_q;
	logic [12:0] out_len_q, out_free_q;
	logic out_load;

	assign s_axis_tready = (state_q == IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = {3'b0, out_free_q, out_len_q, out_res_q, out_st_q};
	assign out_load = (state_q == DONE) && (!out_v_q || m_axis_tready);

	always_comb begin
		we = 1'b0;
		addr = cur_q[AW-1:0];
		wdata = FREE_MARK;
		unique case (state_q)
			CLR: begin
				we = 1'b1;
				addr = scan_q[AW-1:0];
			end
			SCAN: addr = scan_q[AW-1:0];
			ALLOC_NEXT: begin
				// Link the previous cluster to the new one when has_previous is set.
				we = prev_q;
				addr = cl_q[AW-1:0];
				wdata = pick_q;
			end
			MARK_END: begin
				we = 1'b1;
				addr = pick_q[AW-1:0];
				wdata = END_MARK;
			end
			REL_WR: begin
				we = 1'b1;
				if (act_q == ACT_WRITE) wdata = val_q;
				else wdata = (first_q && act_q == ACT_FREE_REST) ? END_MARK : FREE_MARK;
			end
			default: ;
		endcase
	end

	// The output register holds a finished transaction until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			out_st_q <= '0;
			out_res_q <= '0;
			out_len_q <= '0;
			out_free_q <= '0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
			out_st_q <= st_q;
			out_res_q <= (st_q != ST_OK) ? 16'd0 : res_q;
			out_len_q <= (st_q != ST_OK) ? 13'd0 : olen_q;
			out_free_q <= 13'(free_q);
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			scan_q <= '0;
			free_q <= CW'(CLUSTERS);
			hint_q <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				CLR: begin
					scan_q <= scan_q + 17'd1;
					if (scan_q == NCL - 17'd1) state_q <= IDLE;
				end
				IDLE: if (s_axis_tvalid && s_axis_tready) begin
					act_q <= s_axis_tdata[2:0];
					cl_q <= s_axis_tdata[18:3];
					prev_q <= s_axis_tdata[19];
					val_q <= s_axis_tdata[35:20];
					cur_q <= s_axis_tdata[18:3];
					st_q <= ST_OK; res_q <= '0; olen_q <= '0;
					len_q <= '0; last_q <= '0; phase_q <= 1'b0;
					case (s_axis_tdata[2:0]) inside
						ACT_ALLOC: begin
							if (s_axis_tdata[19] && {1'b0, s_axis_tdata[18:3]} >= NCL) begin
								st_q <= ST_RANGE; state_q <= DONE;
							end else if (free_q == '0) begin
								st_q <= ST_NO_FREE; state_q <= DONE;
							end else begin
								cur_q <= 16'(hint_q); state_q <= ALLOC_HINT;
							end
						end
						ACT_FREE, ACT_FREE_REST, ACT_COUNT, ACT_LAST: state_q <= WALK;
						default: begin
							if ({1'b0, s_axis_tdata[18:3]} >= NCL) begin
								st_q <= ST_RANGE; state_q <= DONE;
							end else state_q <= RD;
						end
					endcase
				end
				RD: begin
					// Read issued while phase_q is low; data valid once it is high.
					if (!phase_q) phase_q <= 1'b1;
					else begin
						unique case (act_q)
							ACT_READ: res_q <= rdata;
							ACT_WRITE: res_q <= val_q;
							default: begin
								hint_q <= cl_q[AW-1:0];
								free_q <= (val_q > 16'(CLUSTERS)) ? CW'(CLUSTERS) : CW'(val_q);
							end
						endcase
						if (act_q == ACT_WRITE) state_q <= REL_WR;
						else state_q <= DONE;
						first_q <= 1'b0;
						pick_q <= val_q;
					end
				end
				ALLOC_HINT: begin
					if (!phase_q) phase_q <= 1'b1;
					else begin
						phase_q <= 1'b0;
						if (rdata == FREE_MARK) begin
							pick_q <= cur_q; state_q <= ALLOC_NEXT;
						end else begin
							scan_q <= '0; scan_next_q <= 1'b0; state_q <= SCAN;
						end
					end
				end
				SCAN: begin
					// Each entry takes an address phase, then a data phase.
					if (!phase_q) phase_q <= 1'b1;
					else begin
						phase_q <= 1'b0;
						if (rdata == FREE_MARK && !(scan_next_q && scan_q[15:0] == pick_q)) begin
							if (scan_next_q) begin
								hint_q <= scan_q[AW-1:0]; state_q <= DONE;
							end else begin
								pick_q <= scan_q[15:0]; state_q <= ALLOC_NEXT;
							end
						end else if (scan_q == NCL - 17'd1) begin
							if (scan_next_q) begin
								hint_q <= '0; state_q <= DONE;
							end else begin
								st_q <= ST_NO_FREE; state_q <= DONE;
							end
						end else scan_q <= scan_q + 17'd1;
					end
				end
				ALLOC_NEXT: begin
					// The previous cluster is linked in this cycle when requested.
					phase_q <= 1'b0;
					state_q <= MARK_END;
				end
				MARK_END: begin
					// The new cluster becomes the end of its chain; then look for the next hint.
					free_q <= free_q - CW'(1);
					res_q <= pick_q;
					phase_q <= 1'b0;
					if ({1'b0, pick_q} + 17'd1 < NCL) begin
						cur_q <= pick_q + 16'd1; state_q <= CHECK_NEXT;
					end else begin
						scan_q <= '0; scan_next_q <= 1'b1; state_q <= SCAN;
					end
				end
				CHECK_NEXT: begin
					if (!phase_q) phase_q <= 1'b1;
					else begin
						phase_q <= 1'b0;
						if (rdata == FREE_MARK) begin
							hint_q <= cur_q[AW-1:0]; state_q <= DONE;
						end else begin
							scan_q <= '0; scan_next_q <= 1'b1; state_q <= SCAN;
						end
					end
				end
				WALK: begin
					if (cur_q == END_MARK) begin
						if (len_q == '0 && (act_q == ACT_FREE_REST || act_q == ACT_LAST)) begin
							st_q <= ST_EMPTY; state_q <= DONE;
						end else begin
							unique case (act_q)
								ACT_COUNT: begin
									olen_q <= 13'(len_q); state_q <= DONE;
								end
								ACT_LAST: begin
									olen_q <= 13'(len_q); res_q <= last_q; state_q <= DONE;
								end
								default: begin
									cur_q <= cl_q; cnt_q <= '0; first_q <= 1'b1;
									olen_q <= (act_q == ACT_FREE_REST) ? 13'(len_q - 17'd1)
										: 13'(len_q);
									state_q <= (len_q == '0) ? DONE : REL;
								end
							endcase
						end
					end else if ({1'b0, cur_q} >= NCL) begin
						st_q <= ST_RANGE; state_q <= DONE;
					end else if (len_q == NCL) begin
						st_q <= ST_LOOP; state_q <= DONE;
					end else if (!phase_q) phase_q <= 1'b1;
					else begin
						phase_q <= 1'b0;
						len_q <= len_q + 17'd1;
						last_q <= cur_q;
						cur_q <= rdata;
					end
				end
				REL: begin
					if (!phase_q) phase_q <= 1'b1;
					else begin
						phase_q <= 1'b0;
						pick_q <= rdata;
						state_q <= REL_WR;
					end
				end
				REL_WR: begin
					if (act_q == ACT_WRITE) begin
						state_q <= DONE;
					end else begin
						if (!(first_q && act_q == ACT_FREE_REST) && cur_q[AW-1:0] < hint_q)
							hint_q <= cur_q[AW-1:0];
						first_q <= 1'b0;
						cnt_q <= cnt_q + 17'd1;
						cur_q <= pick_q;
						if (cnt_q + 17'd1 == len_q || {1'b0, pick_q} >= NCL) begin
							free_q <= ({1'b0, 17'(free_q)} + 18'(olen_q) > 18'(NCL)) ?
								CW'(CLUSTERS) : CW'(17'(free_q) + 17'(olen_q));
							state_q <= DONE;
						end else state_q <= REL;
					end
				end
				DONE: begin
					if (out_load) state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/fccm_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module fccm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] addr,
	input wire logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// ===== rtl/fccm_checker.sv =====
// Port-level checker for the cluster chain manager, bound to the top level.
// Depends on fccm_pkg and fat_cluster_chain_manager_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "fat_cluster_chain_manager_unit_assert.svh"
module fccm_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic [47:0] m_axis_tdata
);
	import fccm_pkg::*;
	logic [2:0] rsp_status;
	logic [28:0] rsp_body;
	logic [12:0] rsp_free;
	assign rsp_status = m_axis_tdata[2:0];
	assign rsp_body = m_axis_tdata[31:3];
	assign rsp_free = m_axis_tdata[44:32];

	`FCCM_ASSERT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")
	`FCCM_ASSERT(a_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "result changed")
	`FCCM_ASSERT(a_range, clk, arst_n, m_axis_tvalid |-> rsp_free <= 13'(CLUSTERS_DEF), "free total too large")
	`FCCM_ASSERT(a_status, clk, arst_n, m_axis_tvalid |-> rsp_status <= ST_EMPTY, "unknown status")
	`FCCM_ASSERT(a_err, clk, arst_n, m_axis_tvalid && rsp_status != ST_OK |-> rsp_body == '0, "error result not zero")
endmodule
bind fat_cluster_chain_manager_unit fccm_checker u_chk (.*);
`default_nettype wire
